// ----- rtl/dbdc_pkg.sv -----
// shared types, constants and register codes for the dual beam direction counter
package dbdc_pkg;

    localparam int TIME_W  = 32;
    localparam int ECHO_W  = 16;
    localparam int DIST_W  = 14;
    localparam int OUT_W   = 16;
    localparam int PHASE_W = 3;
    localparam int EVENT_W = 2;
    localparam int IDX_W   = 3;
    localparam int DATA_W  = 16;
    localparam int WIN_W   = 16;

    // width to tenths of cm: (width * 2810) >> 14
    localparam int CONV_MULT_W = 12;
    localparam int PROD_W      = ECHO_W + CONV_MULT_W;
    localparam logic [CONV_MULT_W-1:0] CONV_MULT  = 12'd2810;
    localparam int                     CONV_SHIFT = 14;

    localparam logic [DIST_W-1:0] NO_ECHO   = 14'd9990;
    localparam logic [DIST_W-1:0] DIST_MIN  = 14'd20;
    localparam logic [DIST_W-1:0] DIST_MAX  = 14'd4000;

    localparam int HIST_DEPTH = 3;
    localparam int SLOT_W     = 2;

    localparam logic ACT_SAMPLE = 1'b0;
    localparam logic ACT_RESET  = 1'b1;

    // register reset values
    localparam logic [DIST_W-1:0] ENTER_RST    = 14'd300;
    localparam logic [DIST_W-1:0] LEAVE_RST    = 14'd400;
    localparam logic [WIN_W-1:0]  WINDOW_RST   = 16'd1500;
    localparam logic [WIN_W-1:0]  COOLDOWN_RST = 16'd300;
    localparam logic [ECHO_W-1:0] TIMEOUT_RST  = 16'd10000;

    typedef enum logic [IDX_W-1:0] {
        REG_ENTER    = 3'd0,
        REG_LEAVE    = 3'd1,
        REG_WINDOW   = 3'd2,
        REG_COOLDOWN = 3'd3,
        REG_SWAP     = 3'd4,
        REG_TIMEOUT  = 3'd5
    } t_reg_idx;

    typedef enum logic [PHASE_W-1:0] {
        PH_IDLE      = 3'd0,
        PH_IN_START  = 3'd1,
        PH_IN_MID    = 3'd2,
        PH_OUT_START = 3'd3,
        PH_OUT_MID   = 3'd4
    } t_phase;

    typedef enum logic [EVENT_W-1:0] {
        EV_NONE   = 2'd0,
        EV_BOARD  = 2'd1,
        EV_ALIGHT = 2'd2,
        EV_RESET  = 2'd3
    } t_event;

    typedef struct packed {
        logic [DIST_W-1:0] enter_threshold;
        logic [DIST_W-1:0] leave_threshold;
        logic [WIN_W-1:0]  traversal_window_ms;
        logic [WIN_W-1:0]  rearm_ms;
        logic              swap_beams;
        logic [ECHO_W-1:0] echo_timeout_us;
    } t_cfg;

    // item after distance conversion
    typedef struct packed {
        logic              action;
        logic [TIME_W-1:0] now_ms;
        logic [DIST_W-1:0] near_tenths;
        logic [DIST_W-1:0] far_tenths;
    } t_item;

    typedef struct packed {
        t_event             event_res;
        logic [OUT_W-1:0]   occupancy;
        logic [OUT_W-1:0]   boarded_total;
        logic [OUT_W-1:0]   alighted_total;
        logic [DIST_W-1:0]  near_filtered;
        logic [DIST_W-1:0]  far_filtered;
        logic               near_blocked;
        logic               far_blocked;
        logic [PHASE_W-1:0] phase;
    } t_result;

endpackage

// ----- rtl/dbdc_if.sv -----
// channel interfaces: sample input, result output and register write
interface dbdc_in_if;
    logic                          valid;
    logic                          ready;
    logic                          action;
    logic [dbdc_pkg::TIME_W-1:0]   now_ms;
    logic [dbdc_pkg::ECHO_W-1:0]   echo_near_us;
    logic [dbdc_pkg::ECHO_W-1:0]   echo_far_us;

    modport source (output valid, action, now_ms, echo_near_us, echo_far_us, input ready);
    modport sink   (input valid, action, now_ms, echo_near_us, echo_far_us, output ready);
endinterface

interface dbdc_out_if;
    logic                          valid;
    logic                          ready;
    logic [dbdc_pkg::EVENT_W-1:0]  event_res;
    logic [dbdc_pkg::OUT_W-1:0]    occupancy;
    logic [dbdc_pkg::OUT_W-1:0]    boarded_total;
    logic [dbdc_pkg::OUT_W-1:0]    alighted_total;
    logic [dbdc_pkg::DIST_W-1:0]   near_filtered;
    logic [dbdc_pkg::DIST_W-1:0]   far_filtered;
    logic                          near_blocked;
    logic                          far_blocked;
    logic [dbdc_pkg::PHASE_W-1:0]  phase;

    modport source (output valid, event_res, occupancy, boarded_total, alighted_total,
                    near_filtered, far_filtered, near_blocked, far_blocked, phase,
                    input ready);
    modport sink   (input valid, event_res, occupancy, boarded_total, alighted_total,
                    near_filtered, far_filtered, near_blocked, far_blocked, phase,
                    output ready);
endinterface

interface dbdc_cfg_if;
    logic                          valid;
    logic                          ready;
    logic [dbdc_pkg::IDX_W-1:0]    index;
    logic [dbdc_pkg::DATA_W-1:0]   data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

// ----- rtl/dbdc_convert.sv -----
// echo width to distance in tenths of cm, with no-echo detection
module dbdc_convert (
    input  logic [dbdc_pkg::ECHO_W-1:0] i_width_us,
    input  logic [dbdc_pkg::ECHO_W-1:0] i_timeout_us,
    output logic [dbdc_pkg::DIST_W-1:0] o_tenths
);

    logic [dbdc_pkg::PROD_W-1:0] product;
    logic [dbdc_pkg::DIST_W-1:0] tenths;
    logic                        no_echo;

    assign product = dbdc_pkg::PROD_W'(i_width_us) * dbdc_pkg::PROD_W'(dbdc_pkg::CONV_MULT);
    assign tenths  = dbdc_pkg::DIST_W'(product >> dbdc_pkg::CONV_SHIFT);

    assign no_echo = (i_width_us == '0) || (i_width_us >= i_timeout_us)
                  || (tenths < dbdc_pkg::DIST_MIN) || (tenths > dbdc_pkg::DIST_MAX);

    assign o_tenths = no_echo ? dbdc_pkg::NO_ECHO : tenths;

endmodule

// ----- rtl/dbdc_core.sv -----
// median rings, hysteresis latches, traversal machine, counters and result register
module dbdc_core #(
    parameter int COUNT_WIDTH = 16
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_fire,
    input  dbdc_pkg::t_item   i_item,
    input  dbdc_pkg::t_cfg    i_cfg,
    output dbdc_pkg::t_result o_res
);

    localparam logic [COUNT_WIDTH-1:0] CNT_MAX = '1;
    localparam int                     DW      = dbdc_pkg::DIST_W;
    localparam int                     TW      = dbdc_pkg::TIME_W;

    function automatic logic [DW-1:0] mid3(input logic [DW-1:0] a,
                                           input logic [DW-1:0] b,
                                           input logic [DW-1:0] c);
        logic [DW-1:0] m;
        if ((a <= b && b <= c) || (c <= b && b <= a)) begin
            m = b;
        end else if ((b <= a && a <= c) || (c <= a && a <= b)) begin
            m = a;
        end else begin
            m = c;
        end
        return m;
    endfunction

    logic [DW-1:0]                  r_near_hist [dbdc_pkg::HIST_DEPTH];
    logic [DW-1:0]                  r_far_hist  [dbdc_pkg::HIST_DEPTH];
    logic [DW-1:0]                  n_near_hist [dbdc_pkg::HIST_DEPTH];
    logic [DW-1:0]                  n_far_hist  [dbdc_pkg::HIST_DEPTH];
    logic [dbdc_pkg::SLOT_W-1:0]    r_slot, n_slot;
    logic                           r_near_latch, n_near_latch;
    logic                           r_far_latch, n_far_latch;
    dbdc_pkg::t_phase               r_phase, n_phase;
    logic [TW-1:0]                  r_phase_start, n_phase_start;
    logic [TW-1:0]                  r_last_count, n_last_count;
    logic [COUNT_WIDTH-1:0]         r_occ, n_occ;
    logic [COUNT_WIDTH-1:0]         r_board, n_board;
    logic [COUNT_WIDTH-1:0]         r_alight, n_alight;
    dbdc_pkg::t_result              r_res, n_res;
    dbdc_pkg::t_event               n_event;

    logic          sample;
    logic [DW-1:0] med_near, med_far;
    logic          beam0, beam1;
    logic [TW-1:0] phase_age, count_age;
    logic          window_over, cooling;
    logic          count_in, count_out;

    assign sample = (i_item.action == dbdc_pkg::ACT_SAMPLE);

    // ring write at the current slot, median over the updated ring
    always_comb begin
        for (int k = 0; k < dbdc_pkg::HIST_DEPTH; k++) begin
            n_near_hist[k] = r_near_hist[k];
            n_far_hist[k]  = r_far_hist[k];
        end
        n_slot = r_slot;
        if (sample) begin
            n_near_hist[r_slot] = i_item.near_tenths;
            n_far_hist[r_slot]  = i_item.far_tenths;
            n_slot = (r_slot == dbdc_pkg::SLOT_W'(dbdc_pkg::HIST_DEPTH - 1))
                   ? '0 : r_slot + 1'b1;
        end
    end

    assign med_near = mid3(n_near_hist[0], n_near_hist[1], n_near_hist[2]);
    assign med_far  = mid3(n_far_hist[0], n_far_hist[1], n_far_hist[2]);

    always_comb begin
        n_near_latch = r_near_latch;
        n_far_latch  = r_far_latch;
        if (sample) begin
            n_near_latch = r_near_latch ? (med_near < i_cfg.leave_threshold)
                                        : (med_near < i_cfg.enter_threshold);
            n_far_latch  = r_far_latch ? (med_far < i_cfg.leave_threshold)
                                       : (med_far < i_cfg.enter_threshold);
        end
    end

    assign beam0 = i_cfg.swap_beams ? n_far_latch : n_near_latch;
    assign beam1 = i_cfg.swap_beams ? n_near_latch : n_far_latch;

    // wrapping time differences
    assign phase_age   = i_item.now_ms - r_phase_start;
    assign count_age   = i_item.now_ms - r_last_count;
    assign window_over = phase_age > TW'(i_cfg.traversal_window_ms);
    assign cooling     = count_age < TW'(i_cfg.rearm_ms);

    assign count_in  = sample && (r_phase == dbdc_pkg::PH_IN_MID) && !beam0 && !beam1;
    assign count_out = sample && (r_phase == dbdc_pkg::PH_OUT_MID) && !beam0 && !beam1;

    // traversal machine: next state
    always_comb begin
        n_phase       = r_phase;
        n_phase_start = r_phase_start;
        if (!sample) begin
            n_phase = dbdc_pkg::PH_IDLE;
        end else begin
            unique case (r_phase)
                dbdc_pkg::PH_IDLE: begin
                    if (!cooling) begin
                        if (beam0 && !beam1) begin
                            n_phase       = dbdc_pkg::PH_IN_START;
                            n_phase_start = i_item.now_ms;
                        end else if (beam1 && !beam0) begin
                            n_phase       = dbdc_pkg::PH_OUT_START;
                            n_phase_start = i_item.now_ms;
                        end
                    end
                end
                dbdc_pkg::PH_IN_START: begin
                    if (beam1) begin
                        n_phase       = dbdc_pkg::PH_IN_MID;
                        n_phase_start = i_item.now_ms;
                    end else if (window_over) begin
                        n_phase = dbdc_pkg::PH_IDLE;
                    end
                end
                dbdc_pkg::PH_OUT_START: begin
                    if (beam0) begin
                        n_phase       = dbdc_pkg::PH_OUT_MID;
                        n_phase_start = i_item.now_ms;
                    end else if (window_over) begin
                        n_phase = dbdc_pkg::PH_IDLE;
                    end
                end
                dbdc_pkg::PH_IN_MID,
                dbdc_pkg::PH_OUT_MID: begin
                    if ((!beam0 && !beam1) || window_over) begin
                        n_phase = dbdc_pkg::PH_IDLE;
                    end
                end
                default: begin
                    n_phase = dbdc_pkg::PH_IDLE;
                end
            endcase
        end
    end

    // traversal machine: counters and event
    always_comb begin
        n_event      = dbdc_pkg::EV_NONE;
        n_occ        = r_occ;
        n_board      = r_board;
        n_alight     = r_alight;
        n_last_count = r_last_count;
        priority if (!sample) begin
            n_event  = dbdc_pkg::EV_RESET;
            n_occ    = '0;
            n_board  = '0;
            n_alight = '0;
        end else if (count_in) begin
            n_event      = dbdc_pkg::EV_BOARD;
            n_board      = r_board + 1'b1;
            n_occ        = (r_occ == CNT_MAX) ? r_occ : r_occ + 1'b1;
            n_last_count = i_item.now_ms;
        end else if (count_out) begin
            n_event      = dbdc_pkg::EV_ALIGHT;
            n_alight     = r_alight + 1'b1;
            n_occ        = (r_occ == '0) ? r_occ : r_occ - 1'b1;
            n_last_count = i_item.now_ms;
        end else begin
            n_event = dbdc_pkg::EV_NONE;
        end
    end

    always_comb begin
        n_res.event_res      = n_event;
        n_res.occupancy      = dbdc_pkg::OUT_W'(n_occ);
        n_res.boarded_total  = dbdc_pkg::OUT_W'(n_board);
        n_res.alighted_total = dbdc_pkg::OUT_W'(n_alight);
        n_res.near_filtered  = med_near;
        n_res.far_filtered   = med_far;
        n_res.near_blocked   = n_near_latch;
        n_res.far_blocked    = n_far_latch;
        n_res.phase          = n_phase;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < dbdc_pkg::HIST_DEPTH; k++) begin
                r_near_hist[k] <= dbdc_pkg::NO_ECHO;
                r_far_hist[k]  <= dbdc_pkg::NO_ECHO;
            end
            r_slot        <= '0;
            r_near_latch  <= 1'b0;
            r_far_latch   <= 1'b0;
            r_phase       <= dbdc_pkg::PH_IDLE;
            r_phase_start <= '0;
            r_last_count  <= '0;
            r_occ         <= '0;
            r_board       <= '0;
            r_alight      <= '0;
        end else if (i_fire) begin
            for (int k = 0; k < dbdc_pkg::HIST_DEPTH; k++) begin
                r_near_hist[k] <= n_near_hist[k];
                r_far_hist[k]  <= n_far_hist[k];
            end
            r_slot        <= n_slot;
            r_near_latch  <= n_near_latch;
            r_far_latch   <= n_far_latch;
            r_phase       <= n_phase;
            r_phase_start <= n_phase_start;
            r_last_count  <= n_last_count;
            r_occ         <= n_occ;
            r_board       <= n_board;
            r_alight      <= n_alight;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_fire) begin
            r_res <= n_res;
        end
    end

    assign o_res = r_res;

endmodule

// ----- rtl/dual_beam_direction_counter.sv -----
// top level of the dual beam direction counter
//
// two-beam people counter for a door: each sample item carries two echo widths
// (near and far beam, microseconds) and a millisecond timestamp; a reset item
// (action 1) clears occupancy, totals and the traversal phase
// channels: i_in takes items, o_out gives exactly one result per item, i_cfg
// writes the six registers by index (always ready, write only while idle)
// pipeline: stage one converts both widths to tenths of cm (one 16x12 multiply each)
// into the input register; stage two runs the median rings, hysteresis latches,
// traversal machine and counters into the result register
// path: an accepted item goes into the input register, its result into the result register
// throughput: one item per cycle while o_out is taken, limited by the single pass through stage two
// stall: when o_out is not taken, the result register holds and the input
// register still takes one more item; i_in.ready drops only when both are full
// reset: synchronous active low; registers go to their defaults, histories to
// no echo, latches clear, phase idle, counters and time stamps zero
module dual_beam_direction_counter #(
    parameter int COUNT_WIDTH = 16
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    dbdc_in_if.sink         i_in,
    dbdc_out_if.source      o_out,
    dbdc_cfg_if.sink        i_cfg
);

    // configuration registers
    dbdc_pkg::t_cfg r_cfg;

    // stage one: converted item
    logic              r_s1_valid;
    dbdc_pkg::t_item   r_s1_item;
    dbdc_pkg::t_item   s1_item;

    // stage two: result register valid
    logic              r_out_valid;
    dbdc_pkg::t_result res;

    logic s1_ready;
    logic in_fire;
    logic s2_fire;
    logic [dbdc_pkg::DIST_W-1:0] near_tenths;
    logic [dbdc_pkg::DIST_W-1:0] far_tenths;

    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.enter_threshold     <= dbdc_pkg::ENTER_RST;
            r_cfg.leave_threshold     <= dbdc_pkg::LEAVE_RST;
            r_cfg.traversal_window_ms <= dbdc_pkg::WINDOW_RST;
            r_cfg.rearm_ms            <= dbdc_pkg::COOLDOWN_RST;
            r_cfg.swap_beams          <= 1'b0;
            r_cfg.echo_timeout_us     <= dbdc_pkg::TIMEOUT_RST;
        end else if (i_cfg.valid) begin
            unique case (dbdc_pkg::t_reg_idx'(i_cfg.index))
                dbdc_pkg::REG_ENTER:    r_cfg.enter_threshold <= i_cfg.data[dbdc_pkg::DIST_W-1:0];
                dbdc_pkg::REG_LEAVE:    r_cfg.leave_threshold <= i_cfg.data[dbdc_pkg::DIST_W-1:0];
                dbdc_pkg::REG_WINDOW:   r_cfg.traversal_window_ms <= i_cfg.data;
                dbdc_pkg::REG_COOLDOWN: r_cfg.rearm_ms <= i_cfg.data;
                dbdc_pkg::REG_SWAP:     r_cfg.swap_beams <= i_cfg.data[0];
                dbdc_pkg::REG_TIMEOUT:  r_cfg.echo_timeout_us <= i_cfg.data;
                default: begin
                    // unused index, write dropped
                end
            endcase
        end
    end

    // handshake: stage two moves when the result register is free or being taken
    assign s2_fire     = r_s1_valid && (!r_out_valid || o_out.ready);
    assign s1_ready    = !r_s1_valid || s2_fire;
    assign in_fire     = i_in.valid && s1_ready;
    assign i_in.ready  = s1_ready;

    dbdc_convert u_conv_near (
        .i_width_us   (i_in.echo_near_us),
        .i_timeout_us (r_cfg.echo_timeout_us),
        .o_tenths     (near_tenths)
    );

    dbdc_convert u_conv_far (
        .i_width_us   (i_in.echo_far_us),
        .i_timeout_us (r_cfg.echo_timeout_us),
        .o_tenths     (far_tenths)
    );

    always_comb begin
        s1_item.action      = i_in.action;
        s1_item.now_ms      = i_in.now_ms;
        s1_item.near_tenths = near_tenths;
        s1_item.far_tenths  = far_tenths;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (s1_ready) begin
            r_s1_valid <= i_in.valid;
        end
    end

    // input register payload, no reset needed
    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_s1_item <= s1_item;
        end
    end

    dbdc_core #(
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_fire  (s2_fire),
        .i_item  (r_s1_item),
        .i_cfg   (r_cfg),
        .o_res   (res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s2_fire) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    assign o_out.valid          = r_out_valid;
    assign o_out.event_res      = res.event_res;
    assign o_out.occupancy      = res.occupancy;
    assign o_out.boarded_total  = res.boarded_total;
    assign o_out.alighted_total = res.alighted_total;
    assign o_out.near_filtered  = res.near_filtered;
    assign o_out.far_filtered   = res.far_filtered;
    assign o_out.near_blocked   = res.near_blocked;
    assign o_out.far_blocked    = res.far_blocked;
    assign o_out.phase          = res.phase;

endmodule

// ----- verif/tb_dual_beam_direction_counter.sv -----
// self-checking testbench for the dual beam direction counter: directed and random items
`timescale 1ns / 100ps

module tb_dual_beam_direction_counter;
    import dbdc_pkg::*;

    // run limits
    localparam int CYCLE_LIMIT = 300000;
    localparam int HOLD_CYCLES = 400;
    localparam int PRINT_CAP   = 200;

    // crossing shapes for the item generator
    localparam int SHAPE_MIN   = 0;   // short fixed sequence that still counts
    localparam int SHAPE_TIDY  = 1;   // well formed, random stage lengths
    localparam int SHAPE_LOOSE = 2;   // stages may be missing, resets may cut in

    // receiver stall modes
    localparam int RX_STEADY  = 0;
    localparam int RX_RANDOM  = 1;
    localparam int RX_PATTERN = 2;

    typedef struct {
        logic              action;
        logic [TIME_W-1:0] now_ms;
        logic [ECHO_W-1:0] echo_near_us;
        logic [ECHO_W-1:0] echo_far_us;
    } t_sample_item;

    typedef struct {
        t_reg_idx          idx;
        logic [DATA_W-1:0] data;
    } t_reg_write;

    logic i_clk;
    logic i_rst_n;

    dbdc_in_if  in_if ();
    dbdc_out_if out_if ();
    dbdc_cfg_if cfg_if ();

    dual_beam_direction_counter #(.COUNT_WIDTH(16)) dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_if),
        .o_out   (out_if),
        .i_cfg   (cfg_if)
    );

    // items waiting for the driver, results waiting for the monitor
    t_sample_item queued_samples[$];
    t_reg_write   reg_writes[$];
    t_result      awaited_results[$];

    int mismatch_count = 0;
    int results_seen   = 0;
    int cycle_count    = 0;
    int items_made     = 0;

    // sender burst shaping
    int burst_left;
    int gap_left;

    // receiver stall shaping and the long hold-off
    int rx_mode;
    int rx_left;
    int hold_left;
    bit hold_request;

    // generator side: register values being aimed at and the running clock in ms
    t_cfg              plan;
    logic [TIME_W-1:0] stamp;

    // ------------------------------------------------------------------
    // counter model: registers and state as the block should hold them
    // ------------------------------------------------------------------
    t_cfg              live_cfg;
    logic [DIST_W-1:0] hist_near [HIST_DEPTH];
    logic [DIST_W-1:0] hist_far  [HIST_DEPTH];
    int                ring_pos;
    logic              lat_near;
    logic              lat_far;
    t_phase            walk_phase;
    logic [TIME_W-1:0] phase_t0;
    logic [TIME_W-1:0] last_count_t;
    logic [OUT_W-1:0]  occ_count;
    logic [OUT_W-1:0]  board_count;
    logic [OUT_W-1:0]  alight_count;

    // echo width to tenths of cm, no echo for anything out of range
    function automatic logic [DIST_W-1:0] echo_to_tenths(logic [ECHO_W-1:0] w);
        logic [31:0] t;
        if (w == '0 || w >= live_cfg.echo_timeout_us)
            return NO_ECHO;
        t = (32'(w) * 32'(CONV_MULT)) >> CONV_SHIFT;
        if (t < 32'(DIST_MIN) || t > 32'(DIST_MAX))
            return NO_ECHO;
        return t[DIST_W-1:0];
    endfunction

    function automatic logic [DIST_W-1:0] median3(logic [DIST_W-1:0] a, logic [DIST_W-1:0] b,
                                                   logic [DIST_W-1:0] c);
        logic [DIST_W-1:0] lo, hi;
        lo = (a < b) ? a : b;
        hi = (a < b) ? b : a;
        if (c <= lo)
            return lo;
        if (c >= hi)
            return hi;
        return c;
    endfunction

    // one accepted item: update the model state and give the result it causes
    function automatic t_result door_counter_step(logic act, logic [TIME_W-1:0] now,
                                                  logic [ECHO_W-1:0] w_near,
                                                  logic [ECHO_W-1:0] w_far);
        t_result           r;
        logic [DIST_W-1:0] nf, ff;
        logic              b0, b1, other;
        logic [TIME_W-1:0] since_count, since_phase;
        r = '0;
        r.event_res = EV_NONE;
        if (act == ACT_RESET) begin
            // counters and phase clear, histories and latches stay
            occ_count    = '0;
            board_count  = '0;
            alight_count = '0;
            walk_phase   = PH_IDLE;
            r.event_res  = EV_RESET;
        end else begin
            hist_near[ring_pos] = echo_to_tenths(w_near);
            hist_far[ring_pos]  = echo_to_tenths(w_far);
            ring_pos = (ring_pos == HIST_DEPTH - 1) ? 0 : ring_pos + 1;
            nf = median3(hist_near[0], hist_near[1], hist_near[2]);
            ff = median3(hist_far[0], hist_far[1], hist_far[2]);

            // hysteresis: enter level to block, leave level to stay blocked
            lat_near = lat_near ? (nf < live_cfg.leave_threshold)
                                : (nf < live_cfg.enter_threshold);
            lat_far  = lat_far  ? (ff < live_cfg.leave_threshold)
                                : (ff < live_cfg.enter_threshold);
            b0 = live_cfg.swap_beams ? lat_far : lat_near;
            b1 = live_cfg.swap_beams ? lat_near : lat_far;

            since_count = now - last_count_t;
            since_phase = now - phase_t0;
            case (walk_phase)
                PH_IDLE: begin
                    // cooldown after a count keeps idle deaf to the beams
                    if (since_count >= 32'(live_cfg.rearm_ms)) begin
                        if (b0 && !b1) begin
                            walk_phase = PH_IN_START;
                            phase_t0   = now;
                        end else if (b1 && !b0) begin
                            walk_phase = PH_OUT_START;
                            phase_t0   = now;
                        end
                    end
                end
                PH_IN_START, PH_OUT_START: begin
                    other = (walk_phase == PH_IN_START) ? b1 : b0;
                    if (other) begin
                        walk_phase = (walk_phase == PH_IN_START) ? PH_IN_MID : PH_OUT_MID;
                        phase_t0   = now;
                    end else if (since_phase > 32'(live_cfg.traversal_window_ms)) begin
                        walk_phase = PH_IDLE;
                    end
                end
                PH_IN_MID, PH_OUT_MID: begin
                    if (!b0 && !b1) begin
                        if (walk_phase == PH_IN_MID) begin
                            board_count = board_count + 1'b1;
                            if (occ_count != '1)
                                occ_count = occ_count + 1'b1;
                            r.event_res = EV_BOARD;
                        end else begin
                            alight_count = alight_count + 1'b1;
                            if (occ_count != '0)
                                occ_count = occ_count - 1'b1;
                            r.event_res = EV_ALIGHT;
                        end
                        last_count_t = now;
                        walk_phase   = PH_IDLE;
                    end else if (since_phase > 32'(live_cfg.traversal_window_ms)) begin
                        walk_phase = PH_IDLE;
                    end
                end
                default: walk_phase = PH_IDLE;
            endcase
        end
        r.occupancy      = occ_count;
        r.boarded_total  = board_count;
        r.alighted_total = alight_count;
        r.near_filtered  = median3(hist_near[0], hist_near[1], hist_near[2]);
        r.far_filtered   = median3(hist_far[0], hist_far[1], hist_far[2]);
        r.near_blocked   = lat_near;
        r.far_blocked    = lat_far;
        r.phase          = walk_phase;
        return r;
    endfunction

    // ------------------------------------------------------------------
    // clock and watchdog
    // ------------------------------------------------------------------
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("tb_dual_beam_direction_counter: done, errors");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // item driver: bursts of random length, random gaps; predicts on accept
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin : item_driver
        t_sample_item nxt;
        if (!i_rst_n) begin
            in_if.valid <= 1'b0;
            burst_left  <= 0;
            gap_left    <= 0;
        end else begin
            if (in_if.valid && in_if.ready)
                awaited_results.push_back(door_counter_step(in_if.action, in_if.now_ms,
                                                            in_if.echo_near_us,
                                                            in_if.echo_far_us));
            // only move on once the current item is gone
            if (!in_if.valid || in_if.ready) begin
                if (gap_left != 0 || queued_samples.size() == 0) begin
                    in_if.valid <= 1'b0;
                    if (gap_left != 0)
                        gap_left <= gap_left - 1;
                end else begin
                    nxt = queued_samples.pop_front();
                    in_if.valid        <= 1'b1;
                    in_if.action       <= nxt.action;
                    in_if.now_ms       <= nxt.now_ms;
                    in_if.echo_near_us <= nxt.echo_near_us;
                    in_if.echo_far_us  <= nxt.echo_far_us;
                    if (burst_left <= 1) begin
                        burst_left <= $urandom_range(1, 40);
                        // a third of the bursts run straight into the next one
                        gap_left   <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
                    end else begin
                        burst_left <= burst_left - 1;
                    end
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // register write driver: updates the model copy on accept
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin : reg_driver
        t_reg_write w;
        if (!i_rst_n) begin
            cfg_if.valid <= 1'b0;
        end else begin
            if (cfg_if.valid && cfg_if.ready) begin
                case (t_reg_idx'(cfg_if.index))
                    REG_ENTER:    live_cfg.enter_threshold     = cfg_if.data[DIST_W-1:0];
                    REG_LEAVE:    live_cfg.leave_threshold     = cfg_if.data[DIST_W-1:0];
                    REG_WINDOW:   live_cfg.traversal_window_ms = cfg_if.data[WIN_W-1:0];
                    REG_COOLDOWN: live_cfg.rearm_ms            = cfg_if.data[WIN_W-1:0];
                    REG_SWAP:     live_cfg.swap_beams          = cfg_if.data[0];
                    REG_TIMEOUT:  live_cfg.echo_timeout_us     = cfg_if.data[ECHO_W-1:0];
                    default: ;
                endcase
            end
            if (!cfg_if.valid || cfg_if.ready) begin
                if (reg_writes.size() != 0) begin
                    w = reg_writes.pop_front();
                    cfg_if.valid <= 1'b1;
                    cfg_if.index <= w.idx;
                    cfg_if.data  <= w.data;
                end else begin
                    cfg_if.valid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // receiver: stall mode picked anew whenever its run counter ends, hold-off on top
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin : result_receiver
        bit take;
        if (!i_rst_n) begin
            out_if.ready <= 1'b0;
            rx_mode      <= RX_STEADY;
            rx_left      <= 0;
        end else begin
            if (rx_left == 0) begin
                rx_mode <= $urandom_range(RX_STEADY, RX_PATTERN);
                rx_left <= $urandom_range(20, 200);
            end else begin
                rx_left <= rx_left - 1;
            end
            case (rx_mode)
                RX_RANDOM:  take = ($urandom_range(0, 99) >= 35);
                RX_PATTERN: take = (cycle_count % 7) < 4;
                default:    take = 1'b1;
            endcase
            out_if.ready <= take && (hold_left == 0);
        end
    end

    // long hold-off so the block fills up and stalls its input
    always @(posedge i_clk) begin
        if (!i_rst_n)
            hold_left <= 0;
        else if (hold_left != 0)
            hold_left <= hold_left - 1;
        else if (hold_request)
            hold_left <= HOLD_CYCLES;
    end

    // ------------------------------------------------------------------
    // result monitor
    // ------------------------------------------------------------------
    task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
        mismatch_count++;
        if (mismatch_count <= PRINT_CAP)
            $display("mismatch on result %0d at %0t: %s got %0d want %0d",
                     results_seen, $time, what, got, want);
    endtask

    task automatic check_field(string what, logic [31:0] got, logic [31:0] want);
        if (got !== want)
            report_mismatch(what, got, want);
    endtask

    always @(posedge i_clk) begin : result_monitor
        t_result want;
        if (i_rst_n && out_if.valid && out_if.ready) begin
            results_seen++;
            if (awaited_results.size() == 0) begin
                report_mismatch("result with nothing awaited", 32'(out_if.event_res), 0);
            end else begin
                want = awaited_results.pop_front();
                check_field("event_res", 32'(out_if.event_res), 32'(want.event_res));
                check_field("occupancy", 32'(out_if.occupancy), 32'(want.occupancy));
                check_field("boarded_total", 32'(out_if.boarded_total),
                            32'(want.boarded_total));
                check_field("alighted_total", 32'(out_if.alighted_total),
                            32'(want.alighted_total));
                check_field("near_filtered", 32'(out_if.near_filtered),
                            32'(want.near_filtered));
                check_field("far_filtered", 32'(out_if.far_filtered), 32'(want.far_filtered));
                check_field("near_blocked", 32'(out_if.near_blocked), 32'(want.near_blocked));
                check_field("far_blocked", 32'(out_if.far_blocked), 32'(want.far_blocked));
                check_field("phase", 32'(out_if.phase), 32'(want.phase));
            end
        end
    end

    // ------------------------------------------------------------------
    // item generation
    // ------------------------------------------------------------------

    // smallest width whose distance is exactly t tenths
    function automatic logic [ECHO_W-1:0] width_for(int t);
        return 16'((t * 16384 + 2809) / 2810);
    endfunction

    // mostly small steps, sometimes none, now and then past the window
    function automatic logic [TIME_W-1:0] next_stamp();
        int r;
        r = $urandom_range(0, 99);
        if (r < 3)
            stamp = stamp + $urandom_range(0, 2 * int'(plan.traversal_window_ms) + 10);
        else if (r >= 5)
            stamp = stamp + $urandom_range(5, 60);
        return stamp;
    endfunction

    // width that reads as blocked or as clear under the planned thresholds
    function automatic logic [ECHO_W-1:0] beam_width(bit hit);
        int lo_t, hi_t;
        if (hit) begin
            hi_t = int'(plan.enter_threshold < plan.leave_threshold ?
                        plan.enter_threshold : plan.leave_threshold) - 1;
            if (hi_t > int'(DIST_MAX))
                hi_t = int'(DIST_MAX);
            if (hi_t < int'(DIST_MIN))
                return 16'($urandom_range(0, 3000));
            return width_for($urandom_range(int'(DIST_MIN), hi_t));
        end
        lo_t = int'(plan.enter_threshold > plan.leave_threshold ?
                    plan.enter_threshold : plan.leave_threshold) + 1;
        if ($urandom_range(0, 3) == 0 || lo_t > int'(DIST_MAX))
            return ($urandom_range(0, 1) == 0) ? 16'd0 : 16'hFFFF;
        return width_for($urandom_range(lo_t, int'(DIST_MAX)));
    endfunction

    task automatic push_item(logic act, logic [TIME_W-1:0] now,
                             logic [ECHO_W-1:0] w_near, logic [ECHO_W-1:0] w_far);
        t_sample_item s;
        s.action       = act;
        s.now_ms       = now;
        s.echo_near_us = w_near;
        s.echo_far_us  = w_far;
        queued_samples.push_back(s);
        items_made++;
    endtask

    // one person walking through: first beam, both, second beam, clear
    task automatic push_crossing(bit inbound, int shape);
        bit first_near;
        int n_first, n_both, n_second, n_clear;
        first_near = inbound ^ plan.swap_beams;
        case (shape)
            SHAPE_MIN: begin
                n_first = 2; n_both = 2; n_second = 1; n_clear = 2;
            end
            SHAPE_TIDY: begin
                n_first  = $urandom_range(2, 4);
                n_both   = $urandom_range(2, 4);
                n_second = $urandom_range(0, 3);
                n_clear  = $urandom_range(3, 6);
            end
            default: begin
                n_first  = $urandom_range(0, 5);
                n_both   = $urandom_range(0, 5);
                n_second = $urandom_range(0, 5);
                n_clear  = $urandom_range(0, 5);
            end
        endcase
        repeat (n_first)
            push_item(ACT_SAMPLE, next_stamp(), beam_width(first_near), beam_width(!first_near));
        // a reset command landing in the middle of a crossing
        if (shape == SHAPE_LOOSE && $urandom_range(0, 5) == 0)
            push_item(ACT_RESET, next_stamp(), 16'($urandom), 16'($urandom));
        repeat (n_both)
            push_item(ACT_SAMPLE, next_stamp(), beam_width(1'b1), beam_width(1'b1));
        repeat (n_second)
            push_item(ACT_SAMPLE, next_stamp(), beam_width(!first_near), beam_width(first_near));
        repeat (n_clear)
            push_item(ACT_SAMPLE, next_stamp(), beam_width(1'b0), beam_width(1'b0));
    endtask

    // wait until every item is through and every result is back
    task automatic settle();
        while (queued_samples.size() != 0 || in_if.valid || awaited_results.size() != 0)
            @(negedge i_clk);
        repeat (4) @(negedge i_clk);
    endtask

    function automatic t_cfg make_cfg(int enter_v, int leave_v, int window_v, int cool_v,
                                      bit swap_v, int timeout_v);
        t_cfg c;
        c.enter_threshold     = enter_v[DIST_W-1:0];
        c.leave_threshold     = leave_v[DIST_W-1:0];
        c.traversal_window_ms = window_v[WIN_W-1:0];
        c.rearm_ms            = cool_v[WIN_W-1:0];
        c.swap_beams          = swap_v;
        c.echo_timeout_us     = timeout_v[ECHO_W-1:0];
        return c;
    endfunction

    // all six registers, narrow ones with junk in the unused upper bits
    task automatic apply_setting(t_cfg c);
        logic [31:0] junk;
        junk = $urandom;
        plan = c;
        reg_writes.push_back('{REG_ENTER,    {junk[15:14], c.enter_threshold}});
        reg_writes.push_back('{REG_LEAVE,    {junk[31:30], c.leave_threshold}});
        reg_writes.push_back('{REG_WINDOW,   c.traversal_window_ms});
        reg_writes.push_back('{REG_COOLDOWN, c.rearm_ms});
        reg_writes.push_back('{REG_SWAP,     {junk[20:6], c.swap_beams}});
        reg_writes.push_back('{REG_TIMEOUT,  c.echo_timeout_us});
        while (reg_writes.size() != 0 || cfg_if.valid)
            @(negedge i_clk);
    endtask

    // one setting: mostly crossings with random content, plus resets and noise
    task automatic run_setting(t_cfg c, int n_items, bit wrap_clock, bit long_hold);
        int first_item, pick;
        settle();
        apply_setting(c);
        if (wrap_clock)
            stamp = 32'hFFFF_FFFF - $urandom_range(0, 3000);
        // widths at the top of the distance range, only reachable with a long timeout
        if (c.echo_timeout_us > width_for(int'(DIST_MAX) + 1)) begin
            push_item(ACT_SAMPLE, next_stamp(), width_for(int'(DIST_MAX)),
                      width_for(int'(DIST_MAX) + 1));
            push_item(ACT_SAMPLE, next_stamp(), c.echo_timeout_us - 1'b1, c.echo_timeout_us);
        end
        first_item = items_made;
        while (items_made - first_item < n_items) begin
            pick = $urandom_range(0, 99);
            if (pick < 45)
                push_crossing(1'($urandom_range(0, 1)), SHAPE_TIDY);
            else if (pick < 70)
                push_crossing(1'($urandom_range(0, 1)), SHAPE_LOOSE);
            else if (pick < 77)
                push_item(ACT_RESET, next_stamp(), 16'($urandom), 16'($urandom));
            else if (pick < 88)
                repeat ($urandom_range(1, 8))
                    push_item(ACT_SAMPLE, next_stamp(), beam_width(1'b0), beam_width(1'b0));
            else
                repeat ($urandom_range(1, 4))
                    push_item($urandom_range(0, 7) == 0, $urandom,
                              ($urandom_range(0, 1) == 0) ? 16'($urandom)
                                                          : 16'($urandom_range(0, 3000)),
                              ($urandom_range(0, 1) == 0) ? 16'($urandom)
                                                          : 16'($urandom_range(0, 3000)));
        end
        if (long_hold) begin
            hold_request = 1'b1;
            while (hold_left == 0)
                @(negedge i_clk);
            hold_request = 1'b0;
        end
    endtask

    // ------------------------------------------------------------------
    // main sequence
    // ------------------------------------------------------------------
    initial begin : main_sequence
        int i;
        // every block input known from time zero
        i_rst_n            = 1'b0;
        in_if.valid        = 1'b0;
        in_if.action       = ACT_SAMPLE;
        in_if.now_ms       = '0;
        in_if.echo_near_us = '0;
        in_if.echo_far_us  = '0;
        out_if.ready       = 1'b0;
        cfg_if.valid       = 1'b0;
        cfg_if.index       = REG_ENTER;
        cfg_if.data        = '0;
        hold_request       = 1'b0;

        // model state after reset
        live_cfg = make_cfg(ENTER_RST, LEAVE_RST, WINDOW_RST, COOLDOWN_RST, 1'b0, TIMEOUT_RST);
        plan     = live_cfg;
        for (i = 0; i < HIST_DEPTH; i++) begin
            hist_near[i] = NO_ECHO;
            hist_far[i]  = NO_ECHO;
        end
        ring_pos     = 0;
        lat_near     = 1'b0;
        lat_far      = 1'b0;
        walk_phase   = PH_IDLE;
        phase_t0     = '0;
        last_count_t = '0;
        occ_count    = '0;
        board_count  = '0;
        alight_count = '0;
        stamp        = 32'd1000;

        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // directed: width edges under the reset register values
        push_item(ACT_SAMPLE, next_stamp(), 16'd0, 16'd0);
        push_item(ACT_SAMPLE, next_stamp(), 16'hFFFF, 16'hFFFF);
        push_item(ACT_SAMPLE, next_stamp(), 16'd1, 16'd1);
        // just below and at the shortest valid distance
        push_item(ACT_SAMPLE, next_stamp(), width_for(int'(DIST_MIN)) - 1'b1,
                  width_for(int'(DIST_MIN)));
        push_item(ACT_SAMPLE, next_stamp(), width_for(int'(DIST_MIN)),
                  width_for(int'(DIST_MIN)) - 1'b1);
        // echo just under and at the timeout
        push_item(ACT_SAMPLE, next_stamp(), TIMEOUT_RST - 1'b1, TIMEOUT_RST);
        push_item(ACT_RESET, next_stamp(), 16'd0, 16'hFFFF);
        push_item(ACT_SAMPLE, next_stamp(), 16'd0, 16'd0);
        push_item(ACT_SAMPLE, next_stamp(), 16'd0, 16'd0);
        // one boarding, then an alighting that starts inside the cooldown
        push_crossing(1'b1, SHAPE_MIN);
        push_crossing(1'b0, SHAPE_MIN);

        // random part over several register settings, extremes included
        run_setting(make_cfg(300, 400, 1500, 300, 1'b0, 10000), 320, 1'b0, 1'b1);
        run_setting(make_cfg(500, 700, 200, 0, 1'b1, 65535), 320, 1'b1, 1'b0);
        run_setting(make_cfg(0, 0, 0, 65535, 1'b0, 0), 320, 1'b0, 1'b0);
        run_setting(make_cfg(16383, 16383, 65535, 0, 1'b1, 65535), 320, 1'b0, 1'b0);
        // enter level above leave level
        run_setting(make_cfg(600, 100, 500, 50, 1'b0, 12000), 320, 1'b1, 1'b0);
        i = $urandom_range(50, 2000);
        run_setting(make_cfg(i, i + $urandom_range(0, 800), $urandom_range(100, 3000),
                             $urandom_range(0, 500), 1'($urandom_range(0, 1)),
                             $urandom_range(3000, 65535)), 320, 1'b0, 1'b0);

        settle();
        if (mismatch_count == 0)
            $display("tb_dual_beam_direction_counter: done, clean");
        else
            $display("tb_dual_beam_direction_counter: done, errors");
        $finish;
    end

endmodule

// ----- dual_beam_direction_counter.f -----
rtl/dbdc_pkg.sv
rtl/dbdc_if.sv
rtl/dbdc_convert.sv
rtl/dbdc_core.sv
rtl/dual_beam_direction_counter.sv
verif/tb_dual_beam_direction_counter.sv
